/* hdl/fnmi_pkg.sv */
package fnmi_pkg;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  // Queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = 2;
  localparam int QLW    = 3;

  // One stored pixel word: red in the low byte, mask flag on top
  typedef struct packed {
    logic       masked;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } fnmi_pix_t;

  // One classified step as handed from front to back
  typedef struct packed {
    logic      has_out;
    logic      frame_end;
    logic      use_left;
    logic      use_right;
    logic      use_up;
    logic      use_down;
    fnmi_pix_t pix;
    fnmi_pix_t rd_a;
    fnmi_pix_t rd_b;
  } fnmi_step_t;

endpackage

/* hdl/fnmi_front.sv */
module fnmi_front #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [fnmi_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fnmi_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            push,
  output logic                            full,
  input  logic [7:0]                      in_red,
  input  logic [7:0]                      in_green,
  input  logic [7:0]                      in_blue,
  input  logic                            in_is_masked,
  input  logic                            in_flush,
  input  logic [fnmi_pkg::QLW-1:0]        q_level,
  output logic                            q_push,
  output fnmi_pkg::fnmi_step_t            q_data
);
  import fnmi_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int EW = $clog2(MAX_WIDTH + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 1);
  localparam int AW = CW + 1;

  logic [CFG_DATA_W-1:0] frame_width_r, frame_width_nxt;
  logic [CFG_DATA_W-1:0] frame_height_r, frame_height_nxt;
  logic [CW-1:0]         col_r, col_nxt;
  logic [RW-1:0]         row_r, row_nxt;
  logic                  f_valid_r;
  logic                  fwd_r;
  fnmi_step_t            f_rec_r;
  fnmi_pix_t             rd_a_r, rd_b_r;

  fnmi_pix_t             row_mem [2**AW];

  logic [EW-1:0] wid_eff;
  logic [RW-1:0] hgt_eff;
  logic          col_last;
  logic          draining;
  logic          accept;
  logic          step;
  logic          wr_en;
  logic          fwd;
  logic [CW-1:0] col_inc;
  logic [AW-1:0] addr_a;
  logic [AW-1:0] addr_b;
  logic [QLW:0]  inflight;
  fnmi_pix_t     incoming;
  fnmi_step_t    rec;

  // Clamp the frame size registers to the supported range
  always_comb begin
    if (frame_width_r == '0) begin
      wid_eff = EW'(1);
    end else if (32'(frame_width_r) > 32'(MAX_WIDTH)) begin
      wid_eff = EW'(MAX_WIDTH);
    end else begin
      wid_eff = EW'(frame_width_r);
    end
    if (frame_height_r == '0) begin
      hgt_eff = RW'(1);
    end else if (32'(frame_height_r) > 32'(MAX_HEIGHT)) begin
      hgt_eff = RW'(MAX_HEIGHT);
    end else begin
      hgt_eff = RW'(frame_height_r);
    end
  end

  // Classify the item at the current raster position
  assign inflight = {1'b0, q_level} + {{QLW{1'b0}}, f_valid_r};
  assign full     = inflight >= (QLW + 1)'(QDEPTH);
  assign accept   = push && !full;
  assign col_last = (EW'(col_r) + EW'(1)) == wid_eff;
  assign draining = row_r >= hgt_eff;
  assign step     = accept && !(in_flush && !draining);
  assign wr_en    = step && !draining;

  assign incoming.masked = in_is_masked;
  assign incoming.blue   = in_blue;
  assign incoming.green  = in_green;
  assign incoming.red    = in_red;

  // Port A prefetches the right neighbour, or column 0 of the row just finished
  assign col_inc = col_r + CW'(1);
  assign addr_b  = {row_r[0], col_r};
  assign addr_a  = col_last ? {row_r[0], CW'(0)} : {~row_r[0], col_inc};
  assign fwd     = wr_en && (addr_a == addr_b);

  always_comb begin
    rec           = '0;
    rec.has_out   = row_r != '0;
    rec.frame_end = draining && col_last;
    rec.use_left  = col_r != '0;
    rec.use_right = !col_last;
    rec.use_up    = row_r >= RW'(2);
    rec.use_down  = !draining;
    rec.pix       = incoming;
  end

  // Advance the raster position; a write to the frame width or height register restarts the frame
  always_comb begin
    frame_width_nxt  = frame_width_r;
    frame_height_nxt = frame_height_r;
    col_nxt          = col_r;
    row_nxt          = row_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        REG_FRAME_WIDTH: begin
          frame_width_nxt = cfg_data;
          col_nxt         = '0;
          row_nxt         = '0;
        end
        REG_FRAME_HEIGHT: begin
          frame_height_nxt = cfg_data;
          col_nxt          = '0;
          row_nxt          = '0;
        end
        default: begin
        end
      endcase
    end else if (step) begin
      if (col_last) begin
        col_nxt = '0;
        row_nxt = draining ? '0 : row_r + RW'(1);
      end else begin
        col_nxt = col_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= CFG_DATA_W'(640);
      frame_height_r <= CFG_DATA_W'(480);
      col_r          <= '0;
      row_r          <= '0;
      f_valid_r      <= 1'b0;
    end else begin
      frame_width_r  <= frame_width_nxt;
      frame_height_r <= frame_height_nxt;
      col_r          <= col_nxt;
      row_r          <= row_nxt;
      f_valid_r      <= step;
    end
  end

  // Hold the classified step while the row store reads complete
  always_ff @(posedge clk) begin
    if (step) begin
      f_rec_r <= rec;
      fwd_r   <= fwd;
    end
  end

  // Row store: two rows, read before write at the same address
  always_ff @(posedge clk) begin
    if (step) begin
      rd_a_r <= row_mem[addr_a];
      rd_b_r <= row_mem[addr_b];
    end
    if (wr_en) begin
      row_mem[addr_b] <= incoming;
    end
  end

  // Hand the step to the queue
  always_comb begin
    q_data      = f_rec_r;
    q_data.rd_a = fwd_r ? f_rec_r.pix : rd_a_r;
    q_data.rd_b = rd_b_r;
  end
  assign q_push = f_valid_r;

  a_col_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    EW'(col_r) < wid_eff)
    else $error("column position beyond the frame width");

  a_row_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    row_r <= hgt_eff)
    else $error("row position beyond the drain row");

  a_credit: assert property (@(posedge clk) disable iff (!rst_n)
    inflight <= (QLW + 1)'(QDEPTH))
    else $error("more steps in flight than queue entries");

endmodule

/* hdl/fnmi_queue.sv */
module fnmi_queue (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     push,
  input  fnmi_pkg::fnmi_step_t     push_data,
  input  logic                     pop,
  output fnmi_pkg::fnmi_step_t     pop_data,
  output logic                     valid,
  output logic [fnmi_pkg::QLW-1:0] level
);
  import fnmi_pkg::*;

  fnmi_step_t     slots [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QLW-1:0] level_r, level_nxt;
  logic           do_pop;

  assign valid    = level_r != '0;
  assign level    = level_r;
  assign pop_data = slots[rd_ptr_r];
  assign do_pop   = pop && valid;

  // Advance pointers and fill level
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QAW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + QAW'(1) : rd_ptr_r;
    level_nxt  = level_r;
    if (push && !do_pop) begin
      level_nxt = level_r + QLW'(1);
    end else if (!push && do_pop) begin
      level_nxt = level_r - QLW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr_r] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push && (level_r == QLW'(QDEPTH)) |-> do_pop)
    else $error("transfer into a full step queue");

endmodule

/* hdl/fnmi_back.sv */
module fnmi_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  fnmi_pkg::fnmi_step_t q_data,
  output logic                 q_pop,
  output logic [7:0]           out_red,
  output logic [7:0]           out_green,
  output logic [7:0]           out_blue,
  output logic                 out_frame_end,
  output logic                 empty,
  input  logic                 pop
);
  import fnmi_pkg::*;

  localparam logic [9:0] RECIP3 = 10'd683;

  // Window over the row above the incoming one
  fnmi_pix_t  cen_r;
  fnmi_pix_t  lft_r;

  // Sum stage
  logic       s_valid_r;
  logic       s_has_out_r;
  logic       s_end_r;
  fnmi_pix_t  s_cen_r;
  logic [9:0] s_sum_red_r, s_sum_green_r, s_sum_blue_r;
  logic [2:0] s_cnt_r;

  // Output register
  logic       o_valid_r, o_valid_nxt;
  logic [7:0] o_red_r, o_green_r, o_blue_r;
  logic       o_end_r;

  fnmi_pix_t  nb_pix [4];
  logic       nb_use [4];
  logic [9:0] sum_red, sum_green, sum_blue;
  logic [2:0] cnt;
  logic       out_xfer;
  logic       o_room;
  logic       s_take;
  logic       s_free;
  logic       o_load;
  logic [7:0] mean_red, mean_green, mean_blue;

  // Truncated mean of up to four channel values
  function automatic logic [7:0] mean_of(input logic [9:0] s, input logic [2:0] n);
    logic [19:0] prod;
    prod = {10'd0, s} * {10'd0, RECIP3};
    case (n)
      3'd1:    mean_of = s[7:0];
      3'd2:    mean_of = s[8:1];
      3'd3:    mean_of = prod[18:11];
      3'd4:    mean_of = s[9:2];
      default: mean_of = 8'd0;
    endcase
  endfunction

  // Stall chain from the result side back to the queue
  assign out_xfer = pop && o_valid_r;
  assign o_room   = !o_valid_r || out_xfer;
  assign s_take   = s_valid_r && (!s_has_out_r || o_room);
  assign s_free   = !s_valid_r || s_take;
  assign q_pop    = q_valid && s_free;
  assign o_load   = s_take && s_has_out_r;

  // Gather the unmasked neighbours that lie inside the frame
  assign nb_pix[0] = lft_r;
  assign nb_pix[1] = q_data.rd_a;
  assign nb_pix[2] = q_data.rd_b;
  assign nb_pix[3] = q_data.pix;
  assign nb_use[0] = q_data.use_left;
  assign nb_use[1] = q_data.use_right;
  assign nb_use[2] = q_data.use_up;
  assign nb_use[3] = q_data.use_down;

  always_comb begin
    sum_red   = '0;
    sum_green = '0;
    sum_blue  = '0;
    cnt       = '0;
    for (int i = 0; i < 4; i++) begin
      if (nb_use[i] && !nb_pix[i].masked) begin
        sum_red   = sum_red + 10'(nb_pix[i].red);
        sum_green = sum_green + 10'(nb_pix[i].green);
        sum_blue  = sum_blue + 10'(nb_pix[i].blue);
        cnt       = cnt + 3'd1;
      end
    end
  end

  // Shift the window and register the sums
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cen_r         <= q_data.rd_a;
      lft_r         <= cen_r;
      s_has_out_r   <= q_data.has_out;
      s_end_r       <= q_data.frame_end;
      s_cen_r       <= cen_r;
      s_sum_red_r   <= sum_red;
      s_sum_green_r <= sum_green;
      s_sum_blue_r  <= sum_blue;
      s_cnt_r       <= cnt;
    end
  end

  // Divide and pick the pass-through or the filled pixel
  assign mean_red   = mean_of(s_sum_red_r, s_cnt_r);
  assign mean_green = mean_of(s_sum_green_r, s_cnt_r);
  assign mean_blue  = mean_of(s_sum_blue_r, s_cnt_r);

  always_ff @(posedge clk) begin
    if (o_load) begin
      o_red_r   <= s_cen_r.masked ? mean_red : s_cen_r.red;
      o_green_r <= s_cen_r.masked ? mean_green : s_cen_r.green;
      o_blue_r  <= s_cen_r.masked ? mean_blue : s_cen_r.blue;
      o_end_r   <= s_end_r;
    end
  end

  always_comb begin
    o_valid_nxt = o_valid_r;
    if (o_load) begin
      o_valid_nxt = 1'b1;
    end else if (out_xfer) begin
      o_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
      o_valid_r <= 1'b0;
    end else begin
      s_valid_r <= q_pop || (s_valid_r && !s_take);
      o_valid_r <= o_valid_nxt;
    end
  end

  assign empty         = !o_valid_r;
  assign out_red       = o_red_r;
  assign out_green     = o_green_r;
  assign out_blue      = o_blue_r;
  assign out_frame_end = o_end_r;

  a_no_result_lost: assert property (@(posedge clk) disable iff (!rst_n)
    s_valid_r && s_has_out_r && o_valid_r && !out_xfer |=> s_valid_r)
    else $error("waiting result dropped from the sum stage");

endmodule

/* hdl/four_neighbor_mask_inpaint_core.sv */
// Registered output: a result reaches the result ports after the item of the row below
//   (or the flush item) that releases it is accepted; the first row yields no results.
// Throughput: one item per cycle while full is low, set by the single pass through the
//   two-row store (one write and two reads per cycle); a 4-entry step queue decouples
//   the two halves. Reset: synchronous, active low; sets 640 x 480 and the raster
//   position to zero and empties the queue and result stage. The row store is not cleared.
module four_neighbor_mask_inpaint_core #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [fnmi_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fnmi_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            push,
  output logic                            full,
  input  logic [7:0]                      in_red,
  input  logic [7:0]                      in_green,
  input  logic [7:0]                      in_blue,
  input  logic                            in_is_masked,
  input  logic                            in_flush,
  output logic                            empty,
  input  logic                            pop,
  output logic [7:0]                      out_red,
  output logic [7:0]                      out_green,
  output logic [7:0]                      out_blue,
  output logic                            out_frame_end
);
  import fnmi_pkg::*;

  logic           q_push;
  logic           q_pop;
  logic           q_valid;
  logic [QLW-1:0] q_level;
  fnmi_step_t     q_wr_data;
  fnmi_step_t     q_rd_data;

  // Raster position, classification and row store
  fnmi_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .push         (push),
    .full         (full),
    .in_red       (in_red),
    .in_green     (in_green),
    .in_blue      (in_blue),
    .in_is_masked (in_is_masked),
    .in_flush     (in_flush),
    .q_level      (q_level),
    .q_push       (q_push),
    .q_data       (q_wr_data)
  );

  // Step queue
  fnmi_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wr_data),
    .pop       (q_pop),
    .pop_data  (q_rd_data),
    .valid     (q_valid),
    .level     (q_level)
  );

  // Neighbour window, mean and result register
  fnmi_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_data        (q_rd_data),
    .q_pop         (q_pop),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue),
    .out_frame_end (out_frame_end),
    .empty         (empty),
    .pop           (pop)
  );

endmodule
